@@ sv/zhl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package zhl_pkg;

    localparam int NUM_POSITIONS = 45;
    localparam int MASK_W        = 45;
    localparam int BOARD_W       = (NUM_POSITIONS < MASK_W) ? NUM_POSITIONS : MASK_W;
    localparam int POS_W         = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam int KEY_CNT_W     = $clog2(2 * NUM_POSITIONS + 1);
    localparam int TURN_IDX      = 2 * NUM_POSITIONS;

    localparam int STATE_W = 48;
    localparam int HALF_W  = 24;
    localparam int MUL_W   = 35;
    localparam int PROD_W  = HALF_W + MUL_W;
    localparam int DRAW_W  = 32;
    localparam int KEY_W   = 64;

    localparam logic [MUL_W-1:0]   LCG_MUL    = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_ADD    = 48'hB;
    localparam logic [STATE_W-1:0] SEED_RESET = 48'd12345;

    localparam logic [MASK_W-1:0] BOARD_MASK = MASK_W'((65'd1 << BOARD_W) - 65'd1);

    typedef struct packed {
        logic                 load;
        logic [STATE_W-1:0]   load_value;
        logic                 step;
    } lcg_ctrl_t;

    typedef struct packed {
        logic                 done;
        logic [DRAW_W-1:0]    draw;
    } lcg_stat_t;

    // index of the lowest set bit
    function automatic logic [POS_W-1:0] lowest_set(input logic [MASK_W-1:0] mask);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

@@ sv/zhl_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface zhl_in_if;
    logic                        valid;
    logic                        ready;
    logic [zhl_pkg::MASK_W-1:0]  own_pieces;
    logic [zhl_pkg::MASK_W-1:0]  other_pieces;
    logic                        opponent_to_move;

    modport source (output valid, output own_pieces, output other_pieces,
                    output opponent_to_move, input ready);
    modport sink (input valid, input own_pieces, input other_pieces,
                  input opponent_to_move, output ready);
endinterface
`default_nettype wire

@@ sv/zhl_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface zhl_out_if;
    logic                       valid;
    logic                       ready;
    logic [zhl_pkg::KEY_W-1:0]  hash;

    modport source (output valid, output hash, input ready);
    modport sink (input valid, input hash, output ready);
endinterface
`default_nettype wire

@@ sv/zobrist_hash_with_lcg_keys_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// each request scans popcount(own_pieces | other_pieces) occupied positions, with one read
//   of the two key memories per occupied position
// throughput: one request at a time; the next is taken once the result is registered
// reset and every seed write refill the key table with 2 * (2 * 45 + 1) generator draws,
//   two per key, with no request taken meanwhile
module zobrist_hash_with_lcg_keys_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [zhl_pkg::STATE_W-1:0]   cfg_wdata,
    zhl_in_if.sink                             pos,
    zhl_out_if.source                          res
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_REQ  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_IDLE = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [zhl_pkg::STATE_W-1:0]     seed_reg;
    logic [zhl_pkg::KEY_CNT_W-1:0]   key_cnt_reg;
    logic                            half_reg;
    logic [zhl_pkg::DRAW_W-1:0]      hi_word_reg;
    logic [zhl_pkg::KEY_W-1:0]       turn_key_reg;

    logic [zhl_pkg::KEY_W-1:0]       own_mem [zhl_pkg::NUM_POSITIONS];
    logic [zhl_pkg::KEY_W-1:0]       other_mem [zhl_pkg::NUM_POSITIONS];

    logic [zhl_pkg::MASK_W-1:0]      own_mask_reg;
    logic [zhl_pkg::MASK_W-1:0]      other_mask_reg;
    logic [zhl_pkg::MASK_W-1:0]      pend_reg;
    logic                            turn_sel_reg;
    logic                            rd_vld_reg;
    logic                            sel_own_reg;
    logic                            sel_other_reg;
    logic [zhl_pkg::KEY_W-1:0]       own_rd_reg;
    logic [zhl_pkg::KEY_W-1:0]       other_rd_reg;
    logic [zhl_pkg::KEY_W-1:0]       acc_reg;
    logic                            out_valid_reg;
    logic [zhl_pkg::KEY_W-1:0]       out_hash_reg;

    zhl_pkg::lcg_ctrl_t              lcg_ctrl;
    zhl_pkg::lcg_stat_t              lcg_stat;

    logic                            key_done;
    logic [zhl_pkg::KEY_W-1:0]       key_wr;
    logic [zhl_pkg::POS_W-1:0]       wr_addr;
    logic                            turn_we;
    logic                            own_we;
    logic                            other_we;
    logic                            accept;
    logic                            scan_issue;
    logic [zhl_pkg::POS_W-1:0]       rd_addr;
    logic                            out_free;

    zhl_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lcg_ctrl),
        .stat  (lcg_stat)
    );

    assign lcg_ctrl.load       = (state_reg == ST_LOAD);
    assign lcg_ctrl.load_value = seed_reg ^ zhl_pkg::STATE_W'(zhl_pkg::LCG_MUL);
    assign lcg_ctrl.step       = (state_reg == ST_REQ);

    // key = (first draw << 32) + sign-extended second draw
    assign key_done = (state_reg == ST_WAIT) && lcg_stat.done && half_reg;
    assign key_wr   = {hi_word_reg - zhl_pkg::DRAW_W'(lcg_stat.draw[zhl_pkg::DRAW_W-1]),
                       lcg_stat.draw};
    assign wr_addr  = key_cnt_reg[zhl_pkg::POS_W:1];
    assign turn_we  = key_done && (key_cnt_reg == zhl_pkg::KEY_CNT_W'(zhl_pkg::TURN_IDX));
    assign own_we   = key_done && !turn_we && !key_cnt_reg[0];
    assign other_we = key_done && !turn_we && key_cnt_reg[0];

    assign accept     = pos.valid && pos.ready;
    assign scan_issue = (state_reg == ST_SCAN) && (pend_reg != '0);
    assign rd_addr    = zhl_pkg::lowest_set(pend_reg);
    assign out_free   = !out_valid_reg || res.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: state_next = ST_REQ;
            ST_REQ:  state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (lcg_stat.done)
                begin
                    state_next = turn_we ? ST_IDLE : ST_REQ;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            seed_reg      <= zhl_pkg::SEED_RESET;
            key_cnt_reg   <= '0;
            half_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (state_reg == ST_LOAD)
            begin
                key_cnt_reg <= '0;
                half_reg    <= 1'b0;
            end
            else if ((state_reg == ST_WAIT) && lcg_stat.done)
            begin
                half_reg <= !half_reg;
                if (half_reg)
                begin
                    key_cnt_reg <= key_cnt_reg + 1'b1;
                end
            end
            rd_vld_reg <= scan_issue;
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WAIT) && lcg_stat.done && !half_reg)
        begin
            hi_word_reg <= lcg_stat.draw;
        end
        if (turn_we)
        begin
            turn_key_reg <= key_wr;
        end
        if (own_we)
        begin
            own_mem[wr_addr] <= key_wr;
        end
        if (other_we)
        begin
            other_mem[wr_addr] <= key_wr;
        end
        own_rd_reg   <= own_mem[rd_addr];
        other_rd_reg <= other_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            own_mask_reg   <= pos.own_pieces & zhl_pkg::BOARD_MASK;
            other_mask_reg <= pos.other_pieces & zhl_pkg::BOARD_MASK;
            pend_reg       <= (pos.own_pieces | pos.other_pieces) & zhl_pkg::BOARD_MASK;
            turn_sel_reg   <= pos.opponent_to_move;
            acc_reg        <= '0;
        end
        else
        begin
            if (scan_issue)
            begin
                // drop the lowest occupied position
                pend_reg <= pend_reg & (pend_reg - 1'b1);
            end
            if (rd_vld_reg)
            begin
                acc_reg <= acc_reg ^ (sel_own_reg ? own_rd_reg : '0)
                                   ^ (sel_other_reg ? other_rd_reg : '0);
            end
        end
        sel_own_reg   <= own_mask_reg[rd_addr];
        sel_other_reg <= other_mask_reg[rd_addr];
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_hash_reg <= acc_reg ^ (turn_sel_reg ? turn_key_reg : '0);
        end
    end

    assign pos.ready = (state_reg == ST_IDLE);
    assign res.valid = out_valid_reg;
    assign res.hash  = out_hash_reg;

endmodule
`default_nettype wire

@@ sv/zhl_lcg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module zhl_lcg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire zhl_pkg::lcg_ctrl_t  ctrl,
    output zhl_pkg::lcg_stat_t       stat
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_ADD  = 2'd3;

    logic [1:0]                    phase_reg;
    logic [1:0]                    phase_next;
    logic [zhl_pkg::STATE_W-1:0]   state_reg;
    logic [zhl_pkg::STATE_W-1:0]   plo_reg;
    logic [zhl_pkg::HALF_W-1:0]    phi_reg;
    logic                          done_reg;
    logic [zhl_pkg::HALF_W-1:0]    mul_op;
    logic [zhl_pkg::PROD_W-1:0]    prod;

    // one multiplier, used for the low half and then the high half of the state
    assign mul_op = (phase_reg == PH_HI) ? state_reg[zhl_pkg::STATE_W-1:zhl_pkg::HALF_W]
                                         : state_reg[zhl_pkg::HALF_W-1:0];
    assign prod = zhl_pkg::PROD_W'(mul_op) * zhl_pkg::PROD_W'(zhl_pkg::LCG_MUL);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (ctrl.step)
                begin
                    phase_next = PH_LO;
                end
            end
            PH_LO:   phase_next = PH_HI;
            PH_HI:   phase_next = PH_ADD;
            PH_ADD:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
        if (ctrl.load)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_ADD) && !ctrl.load;
            if (ctrl.load)
            begin
                state_reg <= ctrl.load_value;
            end
            else if (phase_reg == PH_ADD)
            begin
                state_reg <= plo_reg + {phi_reg, {zhl_pkg::HALF_W{1'b0}}} + zhl_pkg::LCG_ADD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_LO)
        begin
            plo_reg <= prod[zhl_pkg::STATE_W-1:0];
        end
        if (phase_reg == PH_HI)
        begin
            phi_reg <= prod[zhl_pkg::HALF_W-1:0];
        end
    end

    assign stat.done = done_reg;
    assign stat.draw = state_reg[zhl_pkg::STATE_W-1:zhl_pkg::STATE_W-zhl_pkg::DRAW_W];

endmodule
`default_nettype wire

@@ tb/zobrist_hash_with_lcg_keys_top_tb.sv @@
`timescale 1ns / 1ps
module zobrist_hash_with_lcg_keys_top_tb;

    localparam int BOARD = 45;
    localparam logic [47:0] GEN_MUL = 48'h5DEECE66D;
    localparam logic [47:0] GEN_ADD = 48'hB;
    localparam logic [47:0] BOOT_SEED = 48'd12345;
    localparam logic [44:0] FULL_BOARD = {45{1'b1}};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [zhl_pkg::STATE_W-1:0] cfg_wdata;

    zhl_in_if pos_if ();
    zhl_out_if res_if ();

    zobrist_hash_with_lcg_keys_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pos       (pos_if),
        .res       (res_if)
    );

    // predicted key table
    logic [63:0] own_key_tbl [BOARD];
    logic [63:0] other_key_tbl [BOARD];
    logic [63:0] turn_key_val;

    logic [63:0] expected_hashes [$];
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("zobrist_hash_with_lcg_keys_top_tb NOT OK");
        $finish;
    end

    task automatic load_key_table(input logic [47:0] seed_value);
        logic [47:0] lcg;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [63:0] key;
        lcg = seed_value ^ GEN_MUL;
        for (int k = 0; k <= 2 * BOARD; k++)
        begin
            lcg = lcg * GEN_MUL + GEN_ADD;
            hi = lcg[47:16];
            lcg = lcg * GEN_MUL + GEN_ADD;
            lo = lcg[47:16];
            key = {hi, 32'h0} + {{32{lo[31]}}, lo};
            // keys alternate own/other per position, turn key last
            if (k == 2 * BOARD)
                turn_key_val = key;
            else if (k % 2 == 0)
                own_key_tbl[k / 2] = key;
            else
                other_key_tbl[k / 2] = key;
        end
    endtask

    function automatic logic [63:0] position_hash(input logic [44:0] own,
                                                  input logic [44:0] other,
                                                  input logic opp);
        logic [63:0] h;
        h = '0;
        for (int i = 0; i < BOARD; i++)
        begin
            if (own[i])
                h ^= own_key_tbl[i];
            if (other[i])
                h ^= other_key_tbl[i];
        end
        if (opp)
            h ^= turn_key_val;
        return h;
    endfunction

    function automatic logic [44:0] sparse_mask(input int max_bits);
        logic [44:0] m;
        int n;
        m = '0;
        n = $urandom_range(max_bits, 1);
        repeat (n) m[$urandom_range(BOARD - 1)] = 1'b1;
        return m;
    endfunction

    // called in the step right after a rising edge
    task automatic send_position(input logic [44:0] own, input logic [44:0] other,
                                 input logic opp);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            pos_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        pos_if.valid <= 1'b1;
        pos_if.own_pieces <= own;
        pos_if.other_pieces <= other;
        pos_if.opponent_to_move <= opp;
        do
            @(posedge clk);
        while (!pos_if.ready);
        expected_hashes.push_back(position_hash(own, other, opp));
    endtask

    task automatic write_seed(input logic [47:0] seed_value);
        pos_if.valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= seed_value;
        @(posedge clk);
        cfg_we <= 1'b0;
        load_key_table(seed_value);
    endtask

    // result checker and receiver stalls
    initial
    begin
        logic [63:0] want;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected hash %h", res_if.hash);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (res_if.hash !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("hash mismatch: expected %h actual %h", want, res_if.hash);
                    end
                end
            end
            res_if.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic test_reset_seed_positions();
        idle_pct = 0;
        stall_pct = 0;
        send_position('0, '0, 1'b0);
        send_position('0, '0, 1'b1);
        send_position(FULL_BOARD, '0, 1'b0);
        send_position('0, FULL_BOARD, 1'b0);
        send_position(FULL_BOARD, FULL_BOARD, 1'b1);
        send_position(45'h1, '0, 1'b0);
        send_position(45'h1 << (BOARD - 1), '0, 1'b1);
        send_position('0, 45'h1, 1'b0);
        send_position('0, 45'h1 << (BOARD - 1), 1'b0);
        send_position(45'h1555_5555_5555, 45'h0AAA_AAAA_AAAA, 1'b1);
        send_position(45'h0AAA_AAAA_AAAA, 45'h1555_5555_5555, 1'b0);
        send_position(45'h100, 45'h100, 1'b0);
    endtask

    task automatic test_seed_extremes();
        logic [47:0] seeds [3];
        seeds[0] = '0;
        seeds[1] = {48{1'b1}};
        // scrambles to an all-zero generator state
        seeds[2] = GEN_MUL;
        foreach (seeds[s])
        begin
            write_seed(seeds[s]);
            send_position('0, '0, 1'b1);
            send_position(FULL_BOARD, '0, 1'b0);
            send_position('0, FULL_BOARD, 1'b1);
            send_position(45'h1, 45'h1 << (BOARD - 1), 1'b0);
        end
    endtask

    task automatic test_random_positions(input int idle, input int stall, input int count,
                                         input logic [47:0] seed_value);
        logic [44:0] own;
        logic [44:0] other;
        write_seed(seed_value);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count)
        begin
            case ($urandom_range(9))
                0:
                begin
                    own = '0;
                    other = sparse_mask(8);
                end
                1:
                begin
                    own = FULL_BOARD;
                    other = ($urandom_range(1) == 1) ? FULL_BOARD : '0;
                end
                2, 3, 4:
                begin
                    own = sparse_mask(6);
                    other = sparse_mask(6);
                end
                5, 6, 7:
                begin
                    // realistic board: no position held by both sides
                    own = 45'({$urandom(), $urandom()});
                    other = 45'({$urandom(), $urandom()}) & ~own;
                end
                default:
                begin
                    own = 45'({$urandom(), $urandom()});
                    other = 45'({$urandom(), $urandom()});
                end
            endcase
            send_position(own, other, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        pos_if.valid <= 1'b0;
        pos_if.own_pieces <= '0;
        pos_if.other_pieces <= '0;
        pos_if.opponent_to_move <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        load_key_table(BOOT_SEED);

        test_reset_seed_positions();
        test_seed_extremes();
        test_random_positions(0, 0, 375, 48'({$urandom(), $urandom()}));
        test_random_positions(55, 0, 375, BOOT_SEED);
        test_random_positions(0, 55, 375, 48'({$urandom(), $urandom()}));
        test_random_positions(33, 33, 375, 48'({$urandom(), $urandom()}));

        pos_if.valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_hashes.size() == 0)
        begin
            $display("zobrist_hash_with_lcg_keys_top_tb OK");
        end
        else
        begin
            $display("zobrist_hash_with_lcg_keys_top_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ zobrist_hash_with_lcg_keys_top.f @@
sv/zhl_pkg.sv
sv/zhl_in_if.sv
sv/zhl_out_if.sv
sv/zhl_lcg.sv
sv/zobrist_hash_with_lcg_keys_top.sv
tb/zobrist_hash_with_lcg_keys_top_tb.sv
